>>> rtl/mel_feature_agc_requantizer_defines.svh
// Assertion macros for the mel feature AGC requantizer.
// Included by the top level; needs no package.
`ifndef MEL_FEATURE_AGC_REQUANTIZER_DEFINES_SVH
`define MEL_FEATURE_AGC_REQUANTIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MFAR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MFAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mfar_pkg.sv
// Shared widths, register codes, reset values and control structs
// for the mel feature AGC requantizer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfar_pkg;

    localparam int MEL_W      = 32;
    localparam int GAIN_W     = 25;
    localparam int STEP_W     = 16;
    localparam int FEAT_W     = 8;
    localparam int SUM_W      = MEL_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SPCH = 2'd3;

    // reset values, Q2.23 (same scale as the Q9.23 mel values)
    localparam logic signed [GAIN_W-1:0] TARGET_RST   = 25'sd2097152;
    localparam logic signed [GAIN_W-1:0] FLOOR_RST    = -25'sd16777216;
    localparam logic [STEP_W-1:0]        STEP_SIL_RST = 16'd4194;
    localparam logic [STEP_W-1:0]        STEP_SP_RST  = 16'd419;

    // +1.0 in Q9.23 at headroom width
    localparam logic signed [SUM_W-1:0] ONE_Q23 = 33'sd8388608;

    localparam logic signed [FEAT_W-1:0] FEAT_MAX = 8'sd127;
    localparam logic signed [FEAT_W-1:0] FEAT_MIN = -8'sd128;

    typedef struct packed {
        logic store;     // input request accepted, write to hop store
        logic first;     // accepted element is the first of its hop
        logic last_elem; // accepted element closes the hop
        logic head;      // compute headroom from peak
        logic attack;    // apply attack clamp and floor
        logic read;      // read hop store
        logic load_out;  // load output register
        logic out_last;  // loaded feature is the last of the burst
        logic rel_step;  // apply release step
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a feature this cycle
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/mfar_in_if.sv
// Input channel: one mel value request with its VAD flag.
// Depends on mfar_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mfar_in_if
    import mfar_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [MEL_W-1:0] mel_value;
    logic                    voice_active;

    modport source (output valid, output mel_value, output voice_active, input ready);
    modport sink   (input valid, input mel_value, input voice_active, output ready);
endinterface

`default_nettype wire

>>> rtl/mfar_out_if.sv
// Output channel: one int8 feature request with burst end flag.
// Depends on mfar_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mfar_out_if
    import mfar_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [FEAT_W-1:0] feature;
    logic                     last_of_hop;

    modport source (output valid, output feature, output last_of_hop, input ready);
    modport sink   (input valid, input feature, input last_of_hop, output ready);
endinterface

`default_nettype wire

>>> rtl/mfar_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mfar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/mfar_ctrl.sv
// Sequencer: hop collection, attack, burst replay and release.
// Depends on mfar_pkg; drives the datapath and hop store address.
`timescale 1ns / 1ps
`default_nettype none

module mfar_ctrl
    import mfar_pkg::*;
#(
    parameter int HOP_SIZE = 40,
    parameter int AW       = (HOP_SIZE > 1) ? $clog2(HOP_SIZE) : 1
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_ctl_cmd        o_cmd,
    output logic [AW-1:0]   o_idx
);

    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_HEAD    = 3'd1;
    localparam logic [2:0] S_ATTACK  = 3'd2;
    localparam logic [2:0] S_READ    = 3'd3;
    localparam logic [2:0] S_EMIT    = 3'd4;
    localparam logic [2:0] S_RELEASE = 3'd5;

    localparam logic [AW-1:0] LAST_IDX = AW'(HOP_SIZE - 1);

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic          w_at_last;

    assign w_at_last = (r_idx == LAST_IDX);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store     = 1'b1;
                    o_cmd.first     = (r_idx == '0);
                    o_cmd.last_elem = w_at_last;
                    if (w_at_last) begin
                        n_idx   = '0;
                        n_state = S_HEAD;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            S_HEAD: begin
                o_cmd.head = 1'b1;
                n_state    = S_ATTACK;
            end
            S_ATTACK: begin
                o_cmd.attack = 1'b1;
                n_state      = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_last = w_at_last;
                    if (w_at_last) begin
                        n_idx   = '0;
                        n_state = S_RELEASE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_RELEASE: begin
                o_cmd.rel_step = 1'b1;
                n_state        = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_idx = r_idx;

endmodule

`default_nettype wire

>>> rtl/mfar_dp.sv
// Datapath: config registers, peak, AGC gain, requantiser, output register.
// Depends on mfar_pkg; commanded by mfar_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module mfar_dp
    import mfar_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  wire t_ctl_cmd                 i_cmd,
    output t_dp_status                    o_status,
    input  wire logic signed [MEL_W-1:0]  i_mel_value,
    input  wire logic                     i_voice_active,
    input  wire logic [MEL_W-1:0]         i_ram_rdata,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [FEAT_W-1:0]      o_feature,
    output logic                          o_last_of_hop
);

    logic signed [GAIN_W-1:0] r_target;
    logic signed [GAIN_W-1:0] r_floor;
    logic [STEP_W-1:0]        r_step_sil;
    logic [STEP_W-1:0]        r_step_sp;
    logic signed [MEL_W-1:0]  r_peak;
    logic                     r_vad;
    logic signed [SUM_W-1:0]  r_head;
    logic signed [GAIN_W-1:0] r_gain;
    logic                     r_out_valid;
    logic signed [FEAT_W-1:0] r_feature;
    logic                     r_last;

    // attack
    logic signed [SUM_W-1:0]  w_gain_x;
    logic signed [SUM_W-1:0]  w_floor_x;
    logic signed [SUM_W-1:0]  w_min;
    logic signed [SUM_W-1:0]  w_att;

    // release
    logic signed [GAIN_W:0]   w_rel_sum;
    logic signed [GAIN_W:0]   w_target_x;
    logic [STEP_W-1:0]        w_step;

    // requantiser
    logic signed [SUM_W-1:0]  w_sum;
    logic                     w_in_range;
    logic [9:0]               w_rnd;
    logic signed [8:0]        w_q9;
    logic signed [FEAT_W-1:0] w_feat;

    assign w_gain_x  = {{(SUM_W-GAIN_W){r_gain[GAIN_W-1]}}, r_gain};
    assign w_floor_x = {{(SUM_W-GAIN_W){r_floor[GAIN_W-1]}}, r_floor};
    assign w_min     = (w_gain_x > r_head) ? r_head : w_gain_x;
    assign w_att     = (w_min < w_floor_x) ? w_floor_x : w_min;

    assign w_step     = r_vad ? r_step_sp : r_step_sil;
    assign w_rel_sum  = {r_gain[GAIN_W-1], r_gain} + {{(GAIN_W+1-STEP_W){1'b0}}, w_step};
    assign w_target_x = {r_target[GAIN_W-1], r_target};

    // value + gain, then clamp to +-1.0 and round to Q1.7
    assign w_sum      = {i_ram_rdata[MEL_W-1], i_ram_rdata} + w_gain_x;
    assign w_in_range = (&w_sum[SUM_W-1:23]) | ~(|w_sum[SUM_W-1:23]);
    assign w_rnd      = {w_sum[23], w_sum[23:15]} + 10'd1;
    assign w_q9       = w_rnd[9:1];

    always_comb begin
        if (!w_in_range) begin
            w_feat = w_sum[SUM_W-1] ? FEAT_MIN : FEAT_MAX;
        end else if (w_q9 == 9'sd128) begin
            w_feat = FEAT_MAX;
        end else begin
            w_feat = w_q9[FEAT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= TARGET_RST;
            r_floor    <= FLOOR_RST;
            r_step_sil <= STEP_SIL_RST;
            r_step_sp  <= STEP_SP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET:    r_target   <= i_cfg_data[GAIN_W-1:0];
                REG_FLOOR:     r_floor    <= i_cfg_data[GAIN_W-1:0];
                REG_STEP_SIL:  r_step_sil <= i_cfg_data[STEP_W-1:0];
                REG_STEP_SPCH: r_step_sp  <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_gain      <= TARGET_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store && (i_cmd.first || (i_mel_value > r_peak))) begin
                r_peak <= i_mel_value;
            end
            if (i_cmd.attack) begin
                // at least floor and otherwise at most old gain, so it fits the gain width
                r_gain <= w_att[GAIN_W-1:0];
            end else if (i_cmd.rel_step && (r_gain < r_target)) begin
                r_gain <= (w_rel_sum > w_target_x) ? r_target : w_rel_sum[GAIN_W-1:0];
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.last_elem) begin
            r_vad <= i_voice_active;
        end
        if (i_cmd.head) begin
            r_head <= ONE_Q23 - {r_peak[MEL_W-1], r_peak};
        end
        if (i_cmd.load_out) begin
            r_feature <= w_feat;
            r_last    <= i_cmd.out_last;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_feature         = r_feature;
    assign o_last_of_hop     = r_last;

endmodule

`default_nettype wire

>>> rtl/mel_feature_agc_requantizer.sv
// Top level of the mel feature AGC requantizer: sequencer, datapath, hop store.
// Depends on mfar_pkg, mfar_in_if, mfar_out_if, mfar_ram, mfar_ctrl, mfar_dp.
//
// Usage:
//  - i_in takes one signed Q9.23 mel value per request, one per cycle while
//    a hop is being collected. voice_active of a hop's last request is kept.
//  - After HOP_SIZE requests the input drops ready. Headroom and attack run
//    first, then the hop is replayed from the hop store: each feature passes
//    a read state, then an emit state that loads it into the output register
//    before the next entry is read, so o_out carries HOP_SIZE int8 features,
//    last_of_hop set on the final one.
//  - After the hop's last request the sequencer steps through HEAD, ATTACK,
//    READ and EMIT; the first feature then shows in the output register.
//  - Replay reads the hop store through its single read port, one entry per feature.
//  - A stalled receiver holds the output register; replay waits in its emit
//    state, so no feature is lost. After the burst the release step runs and
//    input opens again, even while the last feature still waits.
//  - i_cfg_* writes a register at any edge with i_cfg_we high; writes belong
//    between hops. Registers: 0 target, 1 floor, 2 silence step, 3 speech step.
//  - Synchronous reset (i_rst_n low) restores register defaults, empties the
//    hop and sets the gain to its default target. Store contents are kept.
`timescale 1ns / 1ps
`default_nettype none
`include "mel_feature_agc_requantizer_defines.svh"

module mel_feature_agc_requantizer
    import mfar_pkg::*;
#(
    parameter int HOP_SIZE = 40
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    mfar_in_if.sink                    i_in,
    mfar_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (HOP_SIZE > 1) ? $clog2(HOP_SIZE) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(HOP_SIZE - 1);

    t_ctl_cmd          w_cmd;
    t_dp_status        w_status;
    logic [AW-1:0]     w_idx;
    logic [MEL_W-1:0]  w_rdata;
    logic              w_in_ready;

    assign i_in.ready = w_in_ready;

    // sequencer
    mfar_ctrl #(
        .HOP_SIZE (HOP_SIZE),
        .AW       (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    // hop store: written while collecting, read during replay at the same index
    mfar_ram #(
        .WIDTH (MEL_W),
        .DEPTH (HOP_SIZE),
        .AW    (AW)
    ) u_hop_store (
        .i_clk   (i_clk),
        .i_we    (w_cmd.store),
        .i_waddr (w_idx),
        .i_wdata (i_in.mel_value),
        .i_re    (w_cmd.read),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    // gain, requantiser and output register
    mfar_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_mel_value    (i_in.mel_value),
        .i_voice_active (i_in.voice_active),
        .i_ram_rdata    (w_rdata),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_feature      (o_out.feature),
        .o_last_of_hop  (o_out.last_of_hop)
    );

    // output register must be free whenever the sequencer loads it
    `MFAR_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, w_cmd.load_out, w_status.out_free, "feature loaded over a pending one")
    // burst end flag only on the final store entry
    `MFAR_ASSERT_NOW(a_last_at_end, i_clk, i_rst_n, w_cmd.out_last, w_idx == LAST_IDX, "last_of_hop away from hop end")
    // input reopens right after the release step
    `MFAR_ASSERT_NEXT(a_ready_after_rel, i_clk, i_rst_n, w_cmd.rel_step, w_in_ready && (w_idx == '0), "input not reopened after release")

endmodule

`default_nettype wire
